@@ src/cls_pkg.sv @@
// shared types, constants and fixed-point helpers for the cramer solver
package cls_pkg;

  localparam int DIM_W = 4;
  localparam int VAL_W = 32;
  localparam int Q_W   = 64;
  localparam int ST_W  = 2;

  localparam logic [Q_W-1:0]   QMAX    = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [VAL_W-1:0] ONE_Q16 = 32'h0001_0000;

  localparam logic [ST_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [ST_W-1:0] STATUS_SINGULAR = 2'd1;
  localparam logic [ST_W-1:0] STATUS_COUNT    = 2'd2;

  // source of the work matrix write data
  typedef enum logic [2:0] {
    SRC_LOAD,
    SRC_LOAD_NEG,
    SRC_RAW,
    SRC_TMP,
    SRC_MAC
  } wk_src_t;

  typedef enum logic [1:0] {
    OUT_ERR,
    OUT_SING,
    OUT_X,
    OUT_ONE
  } out_sel_t;

  typedef enum logic {
    MUL_ELIM,
    MUL_PROD
  } mul_sel_t;

  typedef enum logic {
    DIV_COEF,
    DIV_SOL
  } div_sel_t;

  typedef struct packed {
    logic     ld_we;
    logic     ld_re;
    logic     wk_we;
    wk_src_t  wk_src;
    logic     tmp_ld;
    logic     pivot_ld;
    logic     mik_ld;
    logic     coef_ld;
    logic     piv_ld;
    logic     piv_neg;
    logic     acc_clr;
    logic     acc_ld_rd;
    logic     acc_ld_mul;
    logic     main_det_ld;
    logic     mul_start;
    mul_sel_t mul_sel;
    logic     div_start;
    div_sel_t div_sel;
    logic     out_ld;
    out_sel_t out_sel;
  } cls_cmd_t;

  typedef struct packed {
    logic wk_zero;
    logic acc_zero;
    logic mul_done;
    logic div_done;
  } cls_sts_t;

  function automatic logic [Q_W-1:0] mag(input logic signed [Q_W-1:0] v);
    logic [Q_W-1:0] u;
    u = v;
    return v[Q_W-1] ? (64'd0 - u) : u;
  endfunction

  // saturate a magnitude to the symmetric range and apply the sign
  function automatic logic signed [Q_W-1:0] sign_sat(input logic [Q_W-1:0] m, input logic neg);
    logic [Q_W-1:0] mm;
    mm = m[Q_W-1] ? QMAX : m;
    return neg ? $signed(64'd0 - mm) : $signed(mm);
  endfunction

  // Q16.16 to Q32.32
  function automatic logic signed [Q_W-1:0] widen(input logic [VAL_W-1:0] raw);
    return $signed({{16{raw[VAL_W-1]}}, raw, 16'h0000});
  endfunction

  function automatic logic signed [Q_W-1:0] add_sat(input logic signed [Q_W-1:0] a,
                                                    input logic signed [Q_W-1:0] b);
    logic signed [Q_W:0] s;
    logic signed [Q_W-1:0] r;
    s = {a[Q_W-1], a} + {b[Q_W-1], b};
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) begin
      r = 64'sh7FFF_FFFF_FFFF_FFFF;
    end else if (s < -65'sh0_7FFF_FFFF_FFFF_FFFF) begin
      r = -64'sh7FFF_FFFF_FFFF_FFFF;
    end else begin
      r = s[Q_W-1:0];
    end
    return r;
  endfunction

  // Q32.32 to saturated Q16.16, truncating toward zero
  function automatic logic [VAL_W-1:0] to_q16(input logic signed [Q_W-1:0] v);
    logic [Q_W-1:0] m;
    logic [VAL_W-1:0] r;
    m = mag(v) >> 16;
    if (v[Q_W-1]) begin
      if (m > 64'h8000_0000) begin
        r = 32'h8000_0000;
      end else begin
        r = 32'(64'd0 - m);
      end
    end else begin
      if (m > 64'h7FFF_FFFF) begin
        r = 32'h7FFF_FFFF;
      end else begin
        r = m[VAL_W-1:0];
      end
    end
    return r;
  endfunction

endpackage

@@ src/cls_if.sv @@
// valid/ready channel interfaces for the solver input and result streams
interface cls_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] element_value;
  logic               last_element;

  modport source (output valid, output element_value, output last_element, input ready);
  modport sink (input valid, input element_value, input last_element, output ready);
endinterface

interface cls_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] solution_value;
  logic [3:0]         solution_index;
  logic               last_result;
  logic [1:0]         status;

  modport source (output valid, output solution_value, output solution_index,
                  output last_result, output status, input ready);
  modport sink (input valid, input solution_value, input solution_index,
                input last_result, input status, output ready);
endinterface

@@ src/cramer_linear_solver.sv @@
// top level of the fixed-point cramer's rule linear system solver
//
// usage:
// - in_ch carries the augmented system one q16.16 element per beat, row by
//   row, the constant vector last; last_element closes the system
// - loading takes one beat per cycle; in_ch.ready stays low from the closing
//   beat until the last result beat of that system has been taken
// - out_ch returns x_0..x_{n-1} in q16.16, then 1.0 at index n with
//   last_result set; a bad element count or a zero det(A) gives a single
//   beat with status set instead
// - the computation is n+1 determinants; each one costs a copy of the matrix,
//   n*(n-1)/2 coefficient divides and (n-1)*n*(2n-1)/6 multiply-adds, plus
//   n-1 product multiplies; a divide runs in the shared bit-serial divider
//   and dominates, a multiply runs in the four-step 32x32 multiplier, plus
//   one final divide per unknown
// - a stalled out_ch holds the result register; nothing else advances
// - reset (rst, synchronous) returns to loading with an empty count and
//   dimension 1; the matrix stores need no clearing
// - write dimension via cfg_wr_en / cfg_wr_data only while idle; unenforced
module cramer_linear_solver #(
  parameter int MAX_DIM = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [cls_pkg::DIM_W-1:0]  cfg_wr_data,
  cls_in_if.sink                     in_ch,
  cls_out_if.source                  out_ch
);
  import cls_pkg::*;

  localparam int LD_AW = $clog2(MAX_DIM * (MAX_DIM + 1));
  localparam int WK_AW = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;

  // command and status between sequencer and datapath
  cls_cmd_t         cmd;
  cls_sts_t         sts;
  logic [LD_AW-1:0] ld_addr;
  logic [WK_AW-1:0] wk_raddr;
  logic [WK_AW-1:0] wk_waddr;
  logic [DIM_W-1:0] idx;
  logic [DIM_W-1:0] out_index;

  // sequencer: load counting, elimination loops, output handshake
  cls_ctrl #(
    .MAX_DIM (MAX_DIM)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_ch.valid),
    .in_last     (in_ch.last_element),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .sts         (sts),
    .cmd         (cmd),
    .ld_addr     (ld_addr),
    .wk_raddr    (wk_raddr),
    .wk_waddr    (wk_waddr),
    .idx         (idx),
    .out_index   (out_index)
  );

  // stores, arithmetic units and the result register that drives out_ch
  cls_datapath #(
    .MAX_DIM (MAX_DIM)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .ld_addr    (ld_addr),
    .wk_raddr   (wk_raddr),
    .wk_waddr   (wk_waddr),
    .idx        (idx),
    .out_index  (out_index),
    .in_value   (in_ch.element_value),
    .sts        (sts),
    .out_value  (out_ch.solution_value),
    .out_idx    (out_ch.solution_index),
    .out_last   (out_ch.last_result),
    .out_status (out_ch.status)
  );

endmodule

@@ src/cls_mul.sv @@
// multi-cycle q32.32 multiplier built from four 32x32 partial products
module cls_mul (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic signed [63:0]    a,
  input  logic signed [63:0]    b,
  output logic                  done,
  output logic signed [63:0]    result
);
  import cls_pkg::*;

  logic [Q_W-1:0]   ua;
  logic [Q_W-1:0]   ub;
  logic             neg;
  logic [2*Q_W-1:0] prod;
  logic [1:0]       step;
  logic             busy;
  logic [31:0]      opa;
  logic [31:0]      opb;
  logic [Q_W-1:0]   pp;
  logic [2*Q_W-1:0] pp_sh;
  logic [Q_W-1:0]   mag_r;

  assign opa = step[1] ? ua[63:32] : ua[31:0];
  assign opb = step[0] ? ub[63:32] : ub[31:0];
  assign pp  = 64'(opa) * 64'(opb);

  always_comb begin
    case (step)
      2'd0:    pp_sh = 128'(pp);
      2'd3:    pp_sh = 128'(pp) << 64;
      default: pp_sh = 128'(pp) << 32;
    endcase
  end

  assign mag_r  = (prod[127:96] != 32'd0) ? QMAX : prod[95:32];
  assign result = sign_sat(mag_r, neg);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= 2'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= 2'd0;
      end else if (busy) begin
        step <= step + 2'd1;
        if (step == 2'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ua   <= mag(a);
      ub   <= mag(b);
      neg  <= a[63] ^ b[63];
      prod <= '0;
    end else if (busy) begin
      prod <= prod + pp_sh;
    end
  end

endmodule

@@ src/cls_div.sv @@
// restoring q32.32 divider, one quotient bit per cycle
module cls_div (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic signed [63:0]    a,
  input  logic signed [63:0]    b,
  output logic                  done,
  output logic signed [63:0]    result
);
  import cls_pkg::*;

  logic [Q_W-1:0]   ub;
  logic             neg;
  logic [2*Q_W-1:0] num;
  logic [Q_W-1:0]   rem;
  logic [Q_W-1:0]   quo;
  logic             ovf;
  logic [6:0]       cnt;
  logic             busy;
  logic [Q_W:0]     rsh;
  logic [Q_W:0]     diff;
  logic             fits;

  assign rsh    = {rem, num[2*Q_W-1]};
  assign diff   = rsh - {1'b0, ub};
  assign fits   = rsh >= {1'b0, ub};
  assign result = (ub == '0) ? '0 : sign_sat(ovf ? QMAX : quo, neg);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 7'd1;
        if (cnt == 7'd127) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ub  <= mag(b);
      num <= {32'd0, mag(a), 32'd0};
      rem <= '0;
      quo <= '0;
      ovf <= 1'b0;
      neg <= a[63] ^ b[63];
    end else if (busy) begin
      num <= num << 1;
      ovf <= ovf | quo[Q_W-1];
      if (fits) begin
        rem <= diff[Q_W-1:0];
        quo <= {quo[Q_W-2:0], 1'b1};
      end else begin
        rem <= rsh[Q_W-1:0];
        quo <= {quo[Q_W-2:0], 1'b0};
      end
    end
  end

endmodule

@@ src/cls_datapath.sv @@
// matrix stores, working registers, multiplier, divider and result register
module cls_datapath #(
  parameter int MAX_DIM = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  cls_pkg::cls_cmd_t                    cmd,
  input  logic [$clog2(MAX_DIM*(MAX_DIM+1))-1:0] ld_addr,
  input  logic [((MAX_DIM > 1) ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] wk_raddr,
  input  logic [((MAX_DIM > 1) ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] wk_waddr,
  input  logic [cls_pkg::DIM_W-1:0]            idx,
  input  logic [cls_pkg::DIM_W-1:0]            out_index,
  input  logic [cls_pkg::VAL_W-1:0]            in_value,
  output cls_pkg::cls_sts_t                    sts,
  output logic [cls_pkg::VAL_W-1:0]            out_value,
  output logic [cls_pkg::DIM_W-1:0]            out_idx,
  output logic                                 out_last,
  output logic [cls_pkg::ST_W-1:0]             out_status
);
  import cls_pkg::*;

  localparam int LOAD_DEPTH = MAX_DIM * (MAX_DIM + 1);
  localparam int WK_DEPTH   = MAX_DIM * MAX_DIM;
  localparam int IX_AW      = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  logic [VAL_W-1:0]        ld_mem [LOAD_DEPTH];
  logic signed [Q_W-1:0]   wk_mem [WK_DEPTH];
  logic [VAL_W-1:0]        ld_q;
  logic signed [Q_W-1:0]   wk_q;
  logic signed [Q_W-1:0]   wk_wdata;
  logic signed [Q_W-1:0]   tmp;
  logic signed [Q_W-1:0]   pivot;
  logic signed [Q_W-1:0]   mik;
  logic signed [Q_W-1:0]   coef [MAX_DIM];
  logic signed [Q_W-1:0]   piv [MAX_DIM];
  logic signed [Q_W-1:0]   acc;
  logic signed [Q_W-1:0]   main_det;
  logic [IX_AW-1:0]        ix;
  logic signed [Q_W-1:0]   mul_a;
  logic signed [Q_W-1:0]   mul_b;
  logic signed [Q_W-1:0]   mul_res;
  logic                    mul_done;
  logic signed [Q_W-1:0]   div_a;
  logic signed [Q_W-1:0]   div_b;
  logic signed [Q_W-1:0]   div_res;
  logic                    div_done;

  assign ix = idx[IX_AW-1:0];

  assign mul_a = (cmd.mul_sel == MUL_PROD) ? piv[ix] : mik;
  assign mul_b = (cmd.mul_sel == MUL_PROD) ? acc : coef[ix];
  assign div_a = (cmd.div_sel == DIV_SOL) ? acc : wk_q;
  assign div_b = (cmd.div_sel == DIV_SOL) ? main_det : pivot;

  cls_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.mul_start),
    .a      (mul_a),
    .b      (mul_b),
    .done   (mul_done),
    .result (mul_res)
  );

  cls_div u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.div_start),
    .a      (div_a),
    .b      (div_b),
    .done   (div_done),
    .result (div_res)
  );

  always_comb begin
    case (cmd.wk_src)
      SRC_LOAD:     wk_wdata = widen(ld_q);
      SRC_LOAD_NEG: wk_wdata = -widen(ld_q);
      SRC_RAW:      wk_wdata = wk_q;
      SRC_TMP:      wk_wdata = tmp;
      SRC_MAC:      wk_wdata = add_sat(tmp, mul_res);
      default:      wk_wdata = wk_q;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_we) begin
      ld_mem[ld_addr] <= in_value;
    end
    if (cmd.ld_re) begin
      ld_q <= ld_mem[ld_addr];
    end
    if (cmd.wk_we) begin
      wk_mem[wk_waddr] <= wk_wdata;
    end
    wk_q <= wk_mem[wk_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.tmp_ld) begin
      tmp <= wk_q;
    end
    if (cmd.pivot_ld) begin
      pivot <= wk_q;
    end
    if (cmd.mik_ld) begin
      mik <= wk_q;
    end
    if (cmd.coef_ld) begin
      coef[ix] <= -div_res;
    end
    if (cmd.piv_ld) begin
      piv[ix] <= cmd.piv_neg ? -pivot : pivot;
    end
    if (cmd.acc_clr) begin
      acc <= '0;
    end else if (cmd.acc_ld_rd) begin
      acc <= wk_q;
    end else if (cmd.acc_ld_mul) begin
      acc <= mul_res;
    end
    if (cmd.main_det_ld) begin
      main_det <= acc;
    end
    if (cmd.out_ld) begin
      case (cmd.out_sel)
        OUT_ERR: begin
          out_value  <= '0;
          out_idx    <= '0;
          out_last   <= 1'b1;
          out_status <= STATUS_COUNT;
        end
        OUT_SING: begin
          out_value  <= '0;
          out_idx    <= '0;
          out_last   <= 1'b1;
          out_status <= STATUS_SINGULAR;
        end
        OUT_X: begin
          out_value  <= to_q16(div_res);
          out_idx    <= out_index;
          out_last   <= 1'b0;
          out_status <= STATUS_OK;
        end
        OUT_ONE: begin
          out_value  <= ONE_Q16;
          out_idx    <= out_index;
          out_last   <= 1'b1;
          out_status <= STATUS_OK;
        end
        default: begin
          out_value  <= '0;
          out_idx    <= '0;
          out_last   <= 1'b1;
          out_status <= STATUS_COUNT;
        end
      endcase
    end
  end

  assign sts.wk_zero  = (wk_q == '0);
  assign sts.acc_zero = (acc == '0);
  assign sts.mul_done = mul_done;
  assign sts.div_done = div_done;

endmodule

@@ src/cls_ctrl.sv @@
// sequencer for loading, elimination passes and result delivery
module cls_ctrl #(
  parameter int MAX_DIM = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  logic [cls_pkg::DIM_W-1:0]            cfg_wr_data,
  input  logic                                 in_valid,
  input  logic                                 in_last,
  output logic                                 in_ready,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  input  cls_pkg::cls_sts_t                    sts,
  output cls_pkg::cls_cmd_t                    cmd,
  output logic [$clog2(MAX_DIM*(MAX_DIM+1))-1:0] ld_addr,
  output logic [((MAX_DIM > 1) ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] wk_raddr,
  output logic [((MAX_DIM > 1) ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] wk_waddr,
  output logic [cls_pkg::DIM_W-1:0]            idx,
  output logic [cls_pkg::DIM_W-1:0]            out_index
);
  import cls_pkg::*;

  localparam int LOAD_DEPTH = MAX_DIM * (MAX_DIM + 1);
  localparam int LD_AW      = $clog2(LOAD_DEPTH);
  localparam int WK_AW      = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;
  localparam int CNT_W      = $clog2(LOAD_DEPTH + 2);

  typedef enum logic [25:0] {
    S_LOAD     = 26'h000_0001,
    S_CHECK    = 26'h000_0002,
    S_CP_RD    = 26'h000_0004,
    S_CP_WR    = 26'h000_0008,
    S_K_START  = 26'h000_0010,
    S_PIV_CHK  = 26'h000_0020,
    S_SRCH     = 26'h000_0040,
    S_SW_RA    = 26'h000_0080,
    S_SW_RB    = 26'h000_0100,
    S_SW_WA    = 26'h000_0200,
    S_SW_WB    = 26'h000_0400,
    S_CF_RD    = 26'h000_0800,
    S_CF_DIV   = 26'h000_1000,
    S_CF_WAIT  = 26'h000_2000,
    S_EL_I     = 26'h000_4000,
    S_EL_MIK   = 26'h000_8000,
    S_EL_RD    = 26'h001_0000,
    S_EL_MUL   = 26'h002_0000,
    S_EL_WAIT  = 26'h004_0000,
    S_PIV_ST   = 26'h008_0000,
    S_LAST     = 26'h010_0000,
    S_PR_MUL   = 26'h020_0000,
    S_PR_WAIT  = 26'h040_0000,
    S_DET_DONE = 26'h080_0000,
    S_XD_WAIT  = 26'h100_0000,
    S_OUT      = 26'h200_0000
  } state_t;

  state_t           state, state_next;
  logic [DIM_W-1:0] dimension;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] total, total_next;
  logic [DIM_W-1:0] n, n_next;
  logic [DIM_W-1:0] k, k_next;
  logic [DIM_W-1:0] i, i_next;
  logic [DIM_W-1:0] j, j_next;
  logic [DIM_W-1:0] r, r_next;
  logic [DIM_W-1:0] c, c_next;
  logic [DIM_W-1:0] xi, xi_next;
  logic             main_pass, main_pass_next;
  logic             neg_piv, neg_piv_next;
  logic             last_beat, last_beat_next;
  logic [DIM_W-1:0] nm1;
  logic             rep_row;
  logic             bad_count;
  logic [CNT_W-1:0] count_inc;

  function automatic logic [WK_AW-1:0] wa(input logic [DIM_W-1:0] row,
                                          input logic [DIM_W-1:0] col);
    return WK_AW'(int'(row) * MAX_DIM + int'(col));
  endfunction

  assign nm1       = n - 4'd1;
  assign rep_row   = !main_pass && (r == xi);
  assign count_inc = (count <= CNT_W'(LOAD_DEPTH)) ? count + 1'b1 : count;
  assign bad_count = (n == '0) || (int'(n) > MAX_DIM)
                     || (int'(total) != int'(n) * (int'(n) + 1));
  assign in_ready  = (state == S_LOAD);
  assign out_valid = (state == S_OUT);

  always_comb begin
    state_next     = state;
    count_next     = count;
    total_next     = total;
    n_next         = n;
    k_next         = k;
    i_next         = i;
    j_next         = j;
    r_next         = r;
    c_next         = c;
    xi_next        = xi;
    main_pass_next = main_pass;
    neg_piv_next   = neg_piv;
    last_beat_next = last_beat;
    cmd            = '0;
    ld_addr        = count[LD_AW-1:0];
    wk_raddr       = wa(k, k);
    wk_waddr       = wa(r, c);
    idx            = j;
    out_index      = xi;

    case (state)
      S_LOAD: begin
        if (in_valid) begin
          cmd.ld_we  = (count < CNT_W'(LOAD_DEPTH));
          count_next = count_inc;
          if (in_last) begin
            total_next = count_inc;
            count_next = '0;
            n_next     = dimension;
            state_next = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        last_beat_next = 1'b0;
        if (bad_count) begin
          cmd.out_ld     = 1'b1;
          cmd.out_sel    = OUT_ERR;
          last_beat_next = 1'b1;
          state_next     = S_OUT;
        end else begin
          main_pass_next = 1'b1;
          r_next         = '0;
          c_next         = '0;
          state_next     = S_CP_RD;
        end
      end
      S_CP_RD: begin
        cmd.ld_re = 1'b1;
        ld_addr   = rep_row ? LD_AW'(int'(n) * int'(n) + int'(c))
                            : LD_AW'(int'(r) * int'(n) + int'(c));
        state_next = S_CP_WR;
      end
      S_CP_WR: begin
        cmd.wk_we  = 1'b1;
        cmd.wk_src = rep_row ? SRC_LOAD_NEG : SRC_LOAD;
        wk_waddr   = wa(r, c);
        state_next = S_CP_RD;
        if (c == nm1) begin
          c_next = '0;
          if (r == nm1) begin
            k_next       = '0;
            neg_piv_next = 1'b0;
            state_next   = S_K_START;
          end else begin
            r_next = r + 4'd1;
          end
        end else begin
          c_next = c + 4'd1;
        end
      end
      S_K_START: begin
        wk_raddr   = wa(k, k);
        state_next = (k == nm1) ? S_LAST : S_PIV_CHK;
      end
      S_PIV_CHK: begin
        if (sts.wk_zero) begin
          wk_raddr   = wa(k + 4'd1, k);
          r_next     = k + 4'd1;
          state_next = S_SRCH;
        end else begin
          cmd.pivot_ld = 1'b1;
          j_next       = k + 4'd1;
          state_next   = S_CF_RD;
        end
      end
      S_SRCH: begin
        if (!sts.wk_zero) begin
          j_next     = '0;
          state_next = S_SW_RA;
        end else if (r == nm1) begin
          cmd.acc_clr = 1'b1;
          state_next  = S_DET_DONE;
        end else begin
          wk_raddr = wa(r + 4'd1, k);
          r_next   = r + 4'd1;
        end
      end
      S_SW_RA: begin
        wk_raddr   = wa(k, j);
        state_next = S_SW_RB;
      end
      S_SW_RB: begin
        cmd.tmp_ld = 1'b1;
        wk_raddr   = wa(r, j);
        state_next = S_SW_WA;
      end
      S_SW_WA: begin
        cmd.wk_we  = 1'b1;
        cmd.wk_src = SRC_RAW;
        wk_waddr   = wa(k, j);
        state_next = S_SW_WB;
      end
      S_SW_WB: begin
        cmd.wk_we  = 1'b1;
        cmd.wk_src = SRC_TMP;
        wk_waddr   = wa(r, j);
        if (j == nm1) begin
          neg_piv_next = 1'b1;
          state_next   = S_K_START;
        end else begin
          j_next     = j + 4'd1;
          state_next = S_SW_RA;
        end
      end
      S_CF_RD: begin
        wk_raddr   = wa(k, j);
        state_next = S_CF_DIV;
      end
      S_CF_DIV: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_COEF;
        state_next    = S_CF_WAIT;
      end
      S_CF_WAIT: begin
        cmd.div_sel = DIV_COEF;
        if (sts.div_done) begin
          cmd.coef_ld = 1'b1;
          idx         = j;
          if (j == nm1) begin
            i_next     = k + 4'd1;
            state_next = S_EL_I;
          end else begin
            j_next     = j + 4'd1;
            state_next = S_CF_RD;
          end
        end
      end
      S_EL_I: begin
        wk_raddr   = wa(i, k);
        state_next = S_EL_MIK;
      end
      S_EL_MIK: begin
        cmd.mik_ld = 1'b1;
        j_next     = k + 4'd1;
        state_next = S_EL_RD;
      end
      S_EL_RD: begin
        wk_raddr   = wa(i, j);
        state_next = S_EL_MUL;
      end
      S_EL_MUL: begin
        cmd.tmp_ld    = 1'b1;
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = MUL_ELIM;
        idx           = j;
        state_next    = S_EL_WAIT;
      end
      S_EL_WAIT: begin
        cmd.mul_sel = MUL_ELIM;
        if (sts.mul_done) begin
          cmd.wk_we  = 1'b1;
          cmd.wk_src = SRC_MAC;
          wk_waddr   = wa(i, j);
          if (j == nm1) begin
            if (i == nm1) begin
              state_next = S_PIV_ST;
            end else begin
              i_next     = i + 4'd1;
              state_next = S_EL_I;
            end
          end else begin
            j_next     = j + 4'd1;
            state_next = S_EL_RD;
          end
        end
      end
      S_PIV_ST: begin
        cmd.piv_ld   = 1'b1;
        cmd.piv_neg  = neg_piv;
        idx          = k;
        k_next       = k + 4'd1;
        neg_piv_next = 1'b0;
        state_next   = S_K_START;
      end
      S_LAST: begin
        cmd.acc_ld_rd = 1'b1;
        if (n == 4'd1) begin
          state_next = S_DET_DONE;
        end else begin
          k_next     = n - 4'd2;
          state_next = S_PR_MUL;
        end
      end
      S_PR_MUL: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = MUL_PROD;
        idx           = k;
        state_next    = S_PR_WAIT;
      end
      S_PR_WAIT: begin
        cmd.mul_sel = MUL_PROD;
        if (sts.mul_done) begin
          cmd.acc_ld_mul = 1'b1;
          if (k == '0) begin
            state_next = S_DET_DONE;
          end else begin
            k_next     = k - 4'd1;
            state_next = S_PR_MUL;
          end
        end
      end
      S_DET_DONE: begin
        if (main_pass) begin
          if (sts.acc_zero) begin
            cmd.out_ld     = 1'b1;
            cmd.out_sel    = OUT_SING;
            last_beat_next = 1'b1;
            state_next     = S_OUT;
          end else begin
            cmd.main_det_ld = 1'b1;
            main_pass_next  = 1'b0;
            xi_next         = '0;
            r_next          = '0;
            c_next          = '0;
            state_next      = S_CP_RD;
          end
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_SOL;
          state_next    = S_XD_WAIT;
        end
      end
      S_XD_WAIT: begin
        cmd.div_sel = DIV_SOL;
        if (sts.div_done) begin
          cmd.out_ld  = 1'b1;
          cmd.out_sel = OUT_X;
          out_index   = xi;
          state_next  = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          if (last_beat) begin
            state_next = S_LOAD;
          end else if (xi == nm1) begin
            cmd.out_ld     = 1'b1;
            cmd.out_sel    = OUT_ONE;
            out_index      = n;
            last_beat_next = 1'b1;
          end else begin
            xi_next    = xi + 4'd1;
            r_next     = '0;
            c_next     = '0;
            state_next = S_CP_RD;
          end
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      dimension <= 4'd1;
      count     <= '0;
      total     <= '0;
      n         <= '0;
      k         <= '0;
      i         <= '0;
      j         <= '0;
      r         <= '0;
      c         <= '0;
      xi        <= '0;
      main_pass <= 1'b0;
      neg_piv   <= 1'b0;
      last_beat <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      total     <= total_next;
      n         <= n_next;
      k         <= k_next;
      i         <= i_next;
      j         <= j_next;
      r         <= r_next;
      c         <= c_next;
      xi        <= xi_next;
      main_pass <= main_pass_next;
      neg_piv   <= neg_piv_next;
      last_beat <= last_beat_next;
      if (cfg_wr_en) begin
        dimension <= cfg_wr_data;
      end
    end
  end

endmodule
